// File: rtl/ddr_irq_pkg.sv
// Shared types and constants for the disk drive register and IRQ timer unit.
package ddr_irq_pkg;

   // bus operation codes carried in the request tuser
   localparam logic [1:0] OP_READ  = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_TICK  = 2'd2;
   localparam logic [1:0] OP_LOAD  = 2'd3;

   // register addresses
   localparam logic [15:0] ADDR_TMR_LO  = 16'h4020;
   localparam logic [15:0] ADDR_TMR_HI  = 16'h4021;
   localparam logic [15:0] ADDR_TMR_CTL = 16'h4022;
   localparam logic [15:0] ADDR_CTL_LO  = 16'h4020;
   localparam logic [15:0] ADDR_CTL_HI  = 16'h4025;
   localparam logic [15:0] ADDR_DRV_CTL = 16'h4025;
   localparam logic [15:0] ADDR_STATUS  = 16'h4030;
   localparam logic [15:0] ADDR_DATA    = 16'h4031;
   localparam logic [15:0] ADDR_DRIVE   = 16'h4032;
   localparam logic [15:0] ADDR_EXT     = 16'h4033;

   // fixed block lengths and read values
   localparam logic [16:0] LEN_VOLUME = 17'h38;
   localparam logic [16:0] LEN_COUNT  = 17'h02;
   localparam logic [16:0] LEN_HEADER = 17'h10;
   localparam logic [7:0]  DRV_NOT_READY = 8'b110;
   localparam logic [7:0]  DRV_READY     = 8'b100;
   localparam logic [7:0]  EXT_VALUE     = 8'h80;
   localparam logic [7:0]  NO_DATA       = 8'hFF;
   localparam logic [15:0] SEEK_DELAY_RST = 16'd100;

   // header offsets of the file size bytes
   localparam int unsigned HDR_SIZE_LO = 13;
   localparam int unsigned HDR_SIZE_HI = 14;

   typedef enum logic [2:0] {
      KIND_INIT   = 3'd0,
      KIND_VOLUME = 3'd1,
      KIND_COUNT  = 3'd2,
      KIND_HEADER = 3'd3,
      KIND_DATA   = 3'd4
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_LOAD,
      ST_HDR_LO,
      ST_HDR_HI
   } state_type;

endpackage

// File: rtl/disk_drive_regs_with_irq_timer_unit.sv
// Disk drive adapter registers with reload timer and transfer-done interrupt.
// Results are registered; a data-port read passes through the disk store read register and ST_READ.
// Throughput: one item per cycle while results are taken; a data read, a disk byte load
//   and a block start that fetches the file size from the disk store hold off the next item.
// The disk store is a synchronous memory with one write port and one registered read port;
//   the data read, the file-size fetch and the load address reduction set the multi-cycle items.
// Reset clears control registers, timer, flags and block position; the disk store keeps its data.
module disk_drive_regs_with_irq_timer_unit
   import ddr_irq_pkg::*;
#(
   parameter int unsigned DISK_BYTES = 65536
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,   // address[15:0], data[23:16], disk_index[39:24], cycles[49:40]
   input  logic [1:0]  req_tuser,   // op[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // read_data[7:0], irq_assert, irq_clear, mirror_set,
                                    // mirror_horizontal
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_data
);

   localparam int unsigned AW = $clog2(DISK_BYTES);
   localparam longint unsigned RECIP_L = 64'd4294967296 / DISK_BYTES;
   localparam int unsigned RW = 33 - AW;
   localparam logic [RW-1:0] RECIP = RW'(RECIP_L);
   localparam logic [AW:0] DISK_END = (AW+1)'(DISK_BYTES);

   // request fields
   logic [1:0]  op;
   logic [15:0] address;
   logic [7:0]  data;
   logic [15:0] disk_index;
   logic [9:0]  cycles;
   assign op         = req_tuser;
   assign address    = req_tdata[15:0];
   assign data       = req_tdata[23:16];
   assign disk_index = req_tdata[39:24];
   assign cycles     = req_tdata[49:40];

   // state registers
   state_type   state_ff, state_in;
   logic [7:0]  r0_ff, r0_in, r1_ff, r1_in, r2_ff, r2_in, r5_ff, r5_in;
   logic [15:0] timer_ff, timer_in;
   logic [15:0] seek_ff, seek_in;
   logic        tflag_ff, tflag_in, xflag_ff, xflag_in;
   logic [AW-1:0] off_ff, off_in;
   logic [16:0] rpos_ff, rpos_in;
   logic [16:0] blen_ff, blen_in;
   kind_type    kind_ff, kind_in;
   logic [15:0] flen_ff, flen_in;
   logic [7:0]  lo_ff, lo_in;
   logic [15:0] seek_delay_ff;
   logic [15:0] ld_q_ff, ld_q_in, ld_idx_ff, ld_idx_in;
   logic [7:0]  ld_data_ff, ld_data_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [11:0] rsp_ff, rsp_in;

   // disk store
   logic [7:0]    disk_mem [DISK_BYTES];
   logic [7:0]    mem_q;
   logic [AW-1:0] mem_raddr;
   logic          mem_we;
   logic [AW-1:0] mem_waddr;

   logic        accept;
   logic [AW:0] hdr_sum;
   logic [16+RW-1:0] recip_prod;
   logic [31:0] q_times;
   logic [15:0] ld_rem;

   assign req_tready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0, rsp_ff};

   // load address reduction: reciprocal estimate then one correction
   assign recip_prod = 16'(disk_index) * RECIP;
   assign q_times    = 32'(ld_q_ff) * 32'(DISK_BYTES);
   always_comb begin
      ld_rem = ld_idx_ff - q_times[15:0];
      if (32'(ld_rem) >= 32'(DISK_BYTES)) begin
         ld_rem = ld_rem - 16'(DISK_BYTES);
      end
   end
   assign mem_we    = (state_ff == ST_LOAD);
   assign mem_waddr = ld_rem[AW-1:0];

   // next state and result
   always_comb begin
      logic [7:0]  rd;
      logic        ia, ic, ms, mh;
      logic [AW:0] off_sum;
      logic [AW:0] hdr_base;
      logic        rising;
      rd = '0; ia = 1'b0; ic = 1'b0; ms = 1'b0; mh = 1'b0;
      state_in = state_ff;
      r0_in = r0_ff; r1_in = r1_ff; r2_in = r2_ff; r5_in = r5_ff;
      timer_in = timer_ff; seek_in = seek_ff;
      tflag_in = tflag_ff; xflag_in = xflag_ff;
      off_in = off_ff; rpos_in = rpos_ff; blen_in = blen_ff;
      kind_in = kind_ff; flen_in = flen_ff; lo_in = lo_ff;
      ld_q_in = ld_q_ff; ld_idx_in = ld_idx_ff; ld_data_in = ld_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_in = rsp_ff;
      mem_raddr = off_ff;
      off_sum = {1'b0, off_ff} + (AW+1)'(1);
      hdr_base = '0;
      rising = 1'b0;
      hdr_sum = {1'b0, off_ff} + (AW+1)'(HDR_SIZE_HI);

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_IDLE;
               case (op)
                  OP_READ: begin
                     if (address == ADDR_STATUS) begin
                        rd = {6'b0, xflag_ff, tflag_ff};
                        seek_in = '0; tflag_in = 1'b0; xflag_in = 1'b0;
                        ic = 1'b1;
                     end else if (address == ADDR_DATA) begin
                        if (r5_ff[2]) begin
                           tflag_in = 1'b0; xflag_in = 1'b0;
                           ic = 1'b1;
                           seek_in = seek_delay_ff;
                           if (rpos_ff < blen_ff) begin
                              mem_raddr = off_ff;
                              rpos_in = rpos_ff + 17'd1;
                              off_in = (off_sum == DISK_END) ? '0 : off_sum[AW-1:0];
                              state_in = ST_READ;
                           end
                        end else begin
                           rd = NO_DATA;
                        end
                     end else if (address == ADDR_DRIVE) begin
                        rd = (!r5_ff[0] || r5_ff[1]) ? DRV_NOT_READY : DRV_READY;
                     end else if (address == ADDR_EXT) begin
                        rd = EXT_VALUE;
                     end
                  end
                  OP_WRITE: begin
                     if (address >= ADDR_CTL_LO && address <= ADDR_CTL_HI) begin
                        if (address == ADDR_TMR_LO || address == ADDR_TMR_HI) begin
                           seek_in = '0; tflag_in = 1'b0; xflag_in = 1'b0;
                           ic = 1'b1;
                        end else if (address == ADDR_TMR_CTL) begin
                           seek_in = '0; tflag_in = 1'b0; xflag_in = 1'b0;
                           ic = 1'b1;
                           if (data[1]) begin
                              timer_in = {r1_ff, r0_ff};
                           end
                        end else if (address == ADDR_DRV_CTL) begin
                           if (data[1]) begin
                              kind_in = KIND_INIT; off_in = '0; flen_in = '0;
                              blen_in = '0; rpos_in = '0;
                           end
                           rising = data[6] && !r5_ff[6];
                           if (rising) begin
                              rpos_in = '0;
                              case (kind_in)
                                 KIND_INIT: begin
                                    kind_in = KIND_VOLUME; blen_in = LEN_VOLUME;
                                 end
                                 KIND_VOLUME: begin
                                    kind_in = KIND_COUNT; blen_in = LEN_COUNT;
                                 end
                                 KIND_COUNT, KIND_DATA: begin
                                    kind_in = KIND_HEADER; blen_in = LEN_HEADER;
                                    hdr_base = {1'b0, off_in} + (AW+1)'(HDR_SIZE_LO);
                                    mem_raddr = (hdr_base >= DISK_END) ?
                                       AW'(hdr_base - DISK_END) : hdr_base[AW-1:0];
                                    state_in = ST_HDR_LO;
                                 end
                                 KIND_HEADER: begin
                                    kind_in = KIND_DATA;
                                    blen_in = 17'd1 + 17'(flen_ff);
                                 end
                                 default: ;
                              endcase
                           end
                           if (data[6]) begin
                              seek_in = seek_delay_ff;
                           end
                           if ((data[3] != r5_ff[3]) || (r5_ff == 8'd0)) begin
                              ms = 1'b1;
                              mh = data[3];
                           end
                        end
                        case (address[2:0])
                           3'd0: r0_in = data;
                           3'd1: r1_in = data;
                           3'd2: r2_in = data;
                           3'd5: r5_in = data;
                           default: ;
                        endcase
                     end
                  end
                  OP_TICK: begin
                     if (timer_ff != 16'd0 && r2_ff[1]) begin
                        if (16'(cycles) >= timer_ff) begin
                           if (!r2_ff[0]) begin
                              r2_in = r2_ff & 8'hFD;
                           end
                           timer_in = {r1_ff, r0_ff};
                           ia = 1'b1;
                           tflag_in = 1'b1;
                        end else begin
                           timer_in = timer_ff - 16'(cycles);
                        end
                     end
                     if (seek_ff != 16'd0) begin
                        if (16'(cycles) >= seek_ff) begin
                           seek_in = '0;
                           if (r5_ff[7]) begin
                              ia = 1'b1;
                           end
                           xflag_in = 1'b1;
                        end else begin
                           seek_in = seek_ff - 16'(cycles);
                        end
                     end
                  end
                  default: begin
                     ld_q_in = 16'(recip_prod >> 32);
                     ld_idx_in = disk_index;
                     ld_data_in = data;
                     state_in = ST_LOAD;
                  end
               endcase
               if (state_in != ST_READ) begin
                  rsp_valid_in = 1'b1;
                  rsp_in = {mh, ms, ic, ia, rd};
               end
            end
         end
         ST_READ: begin
            rsp_valid_in = 1'b1;
            rsp_in = {1'b0, 1'b0, 1'b1, 1'b0, mem_q};
            state_in = ST_IDLE;
         end
         ST_LOAD: begin
            state_in = ST_IDLE;
         end
         ST_HDR_LO: begin
            lo_in = mem_q;
            mem_raddr = (hdr_sum >= DISK_END) ? AW'(hdr_sum - DISK_END) : hdr_sum[AW-1:0];
            state_in = ST_HDR_HI;
         end
         ST_HDR_HI: begin
            flen_in = {mem_q, lo_ff};
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // disk store: one write, one registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         disk_mem[mem_waddr] <= ld_data_ff;
      end
      mem_q <= disk_mem[mem_raddr];
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         r0_ff <= '0; r1_ff <= '0; r2_ff <= '0; r5_ff <= '0;
         timer_ff <= '0; seek_ff <= '0;
         tflag_ff <= 1'b0; xflag_ff <= 1'b0;
         off_ff <= '0; rpos_ff <= '0; blen_ff <= '0;
         kind_ff <= KIND_INIT; flen_ff <= '0;
         seek_delay_ff <= SEEK_DELAY_RST;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         r0_ff <= r0_in; r1_ff <= r1_in; r2_ff <= r2_in; r5_ff <= r5_in;
         timer_ff <= timer_in; seek_ff <= seek_in;
         tflag_ff <= tflag_in; xflag_ff <= xflag_in;
         off_ff <= off_in; rpos_ff <= rpos_in; blen_ff <= blen_in;
         kind_ff <= kind_in; flen_ff <= flen_in;
         if (csr_valid && csr_ready) begin
            seek_delay_ff <= csr_data;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      lo_ff <= lo_in;
      ld_q_ff <= ld_q_in;
      ld_idx_ff <= ld_idx_in;
      ld_data_ff <= ld_data_in;
   end

   // checks
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> state_ff == ST_IDLE) else $error("ready while busy");
   a_read_slot: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_READ |-> !rsp_valid_ff) else $error("data read with result pending");
   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      rpos_ff <= blen_ff) else $error("read position past block end");
   a_off_bound: assert property (@(posedge clock) disable iff (reset)
      {1'b0, off_ff} < DISK_END) else $error("disk offset out of range");
   a_hdr_seq: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_HDR_LO |=> state_ff == ST_HDR_HI) else $error("header fetch broken");

endmodule

// File: tb/tb_disk_drive_regs_with_irq_timer_unit.sv
// Self-checking stream testbench for the disk drive register and IRQ timer unit.
`timescale 1ns / 1ps

module tb_disk_drive_regs_with_irq_timer_unit;
   import ddr_irq_pkg::*;

   localparam int DISK_N     = 65536;
   localparam int WDOG_LIMIT = 5000;
   localparam int HOLD_LEN   = 400;
   localparam int PHASE_ITEMS = 240;

   typedef struct packed {
      logic [1:0]  op;
      logic [15:0] address;
      logic [7:0]  data;
      logic [15:0] disk_index;
      logic [9:0]  cycles;
   } bus_item_t;

   typedef struct packed {
      logic [7:0] read_data;
      logic       irq_assert;
      logic       irq_clear;
      logic       mirror_set;
      logic       mirror_horizontal;
   } bus_result_t;

   typedef struct packed {
      logic [7:0][7:0] regs;
      logic [17:0]     timer_count;
      logic            timer_flag;
      logic [17:0]     seek_count;
      logic            transfer_flag;
      logic [15:0]     block_base;
      logic [16:0]     read_pos;
      logic [16:0]     block_length;
      kind_type        block_kind;
      logic [15:0]     file_length;
      logic [15:0]     seek_delay;
   } drive_state_t;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [55:0] req_tdata;
   logic [1:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;
   logic        csr_valid;
   logic        csr_ready;
   logic [15:0] csr_data;

   disk_drive_regs_with_irq_timer_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   // two copies of the drive: one advanced as items are queued, one as they are accepted
   drive_state_t gen_s, dut_s;
   bit [7:0]     gen_img [DISK_N];
   bit [7:0]     dut_img [DISK_N];
   bit           gen_written [DISK_N];

   bus_item_t    item_q [$];
   bus_result_t  result_q [$];

   bit  calm;
   bit  req_taken;
   int  gap_left;
   int  reqs_in, rsps_out, mismatches, irqs_seen, bytes_read;
   int  idle_cycles;
   bit  held;
   int  hold_left;
   int  rx_gap;

   // clock
   initial clock = 1'b0;
   always #5 clock = ~clock;

   // ---------------------------------------------------------------- predictor
   function automatic void block_advance(ref drive_state_t s, ref bit [7:0] img [DISK_N]);
      logic [31:0] base;
      base = 32'(s.block_base) + 32'(s.read_pos);
      s.block_base = base[15:0];
      s.read_pos = '0;
      case (s.block_kind)
         KIND_INIT: begin
            s.block_kind = KIND_VOLUME;
            s.block_length = LEN_VOLUME;
         end
         KIND_VOLUME: begin
            s.block_kind = KIND_COUNT;
            s.block_length = LEN_COUNT;
         end
         KIND_COUNT, KIND_DATA: begin
            s.block_kind = KIND_HEADER;
            s.block_length = LEN_HEADER;
            s.file_length = {img[16'(s.block_base + HDR_SIZE_HI)],
                             img[16'(s.block_base + HDR_SIZE_LO)]};
         end
         KIND_HEADER: begin
            s.block_kind = KIND_DATA;
            s.block_length = 17'(s.file_length) + 17'd1;
         end
         default: ;
      endcase
   endfunction

   function automatic bus_result_t drive_step(ref drive_state_t s, ref bit [7:0] img [DISK_N],
                                              input bus_item_t it);
      bus_result_t r;
      logic [7:0]  old5;
      logic [31:0] off;
      r = '0;
      case (it.op)
         OP_READ: begin
            if (it.address == ADDR_STATUS) begin
               r.read_data = {6'd0, s.transfer_flag, s.timer_flag};
               s.seek_count = '0; s.transfer_flag = 1'b0; s.timer_flag = 1'b0;
               r.irq_clear = 1'b1;
            end else if (it.address == ADDR_DATA) begin
               if (s.regs[5][2]) begin
                  s.transfer_flag = 1'b0; s.timer_flag = 1'b0;
                  r.irq_clear = 1'b1;
                  s.seek_count = 18'(s.seek_delay);
                  if (s.read_pos < s.block_length) begin
                     off = 32'(s.block_base) + 32'(s.read_pos);
                     r.read_data = img[off[15:0]];
                     s.read_pos++;
                  end
               end else begin
                  r.read_data = NO_DATA;
               end
            end else if (it.address == ADDR_DRIVE) begin
               r.read_data = (!s.regs[5][0] || s.regs[5][1]) ? DRV_NOT_READY : DRV_READY;
            end else if (it.address == ADDR_EXT) begin
               r.read_data = EXT_VALUE;
            end
         end
         OP_WRITE: begin
            if (it.address >= ADDR_CTL_LO && it.address <= ADDR_CTL_HI) begin
               if (it.address == ADDR_TMR_LO || it.address == ADDR_TMR_HI ||
                   it.address == ADDR_TMR_CTL) begin
                  s.seek_count = '0; s.transfer_flag = 1'b0; s.timer_flag = 1'b0;
                  r.irq_clear = 1'b1;
                  if (it.address == ADDR_TMR_CTL && it.data[1])
                     s.timer_count = {2'b0, s.regs[1], s.regs[0]};
               end else if (it.address == ADDR_DRV_CTL) begin
                  old5 = s.regs[5];
                  if (it.data[1]) begin
                     s.block_kind = KIND_INIT;
                     s.block_base = '0; s.file_length = '0;
                     s.block_length = '0; s.read_pos = '0;
                  end
                  if (it.data[6] && !old5[6]) block_advance(s, img);
                  if (it.data[6]) s.seek_count = 18'(s.seek_delay);
                  if (it.data[3] != old5[3] || old5 == 8'd0) begin
                     r.mirror_set = 1'b1;
                     r.mirror_horizontal = it.data[3];
                  end
               end
               s.regs[it.address[2:0]] = it.data;
            end
         end
         OP_TICK: begin
            if (s.timer_count != 0 && s.regs[2][1]) begin
               if (18'(it.cycles) >= s.timer_count) begin
                  if (!s.regs[2][0]) s.regs[2][1] = 1'b0;
                  s.timer_count = {2'b0, s.regs[1], s.regs[0]};
                  r.irq_assert = 1'b1;
                  s.timer_flag = 1'b1;
               end else begin
                  s.timer_count -= 18'(it.cycles);
               end
            end
            if (s.seek_count != 0) begin
               if (18'(it.cycles) >= s.seek_count) begin
                  s.seek_count = '0;
                  if (s.regs[5][7]) r.irq_assert = 1'b1;
                  s.transfer_flag = 1'b1;
               end else begin
                  s.seek_count -= 18'(it.cycles);
               end
            end
         end
         default: img[it.disk_index] = it.data;
      endcase
      return r;
   endfunction

   function automatic drive_state_t drive_reset_state();
      drive_state_t s;
      s = '0;
      s.block_kind = KIND_INIT;
      s.seek_delay = SEEK_DELAY_RST;
      return s;
   endfunction

   // ---------------------------------------------------------------- stimulus helpers
   task automatic put(input logic [1:0] op, input logic [15:0] addr, input logic [7:0] data,
                      input logic [15:0] idx, input logic [9:0] cyc);
      bus_item_t   it;
      bus_result_t unused;
      it = '{op: op, address: addr, data: data, disk_index: idx, cycles: cyc};
      if (op == OP_LOAD) gen_written[idx] = 1'b1;
      unused = drive_step(gen_s, gen_img, it);
      item_q.push_back(it);
   endtask

   // load a disk byte first if the next access would touch an unloaded entry
   task automatic need_byte(input logic [31:0] off);
      if (!gen_written[off[15:0]])
         put(OP_LOAD, 16'($urandom), 8'($urandom), off[15:0], 10'($urandom));
   endtask

   task automatic data_read();
      logic [31:0] off;
      off = 32'(gen_s.block_base) + 32'(gen_s.read_pos);
      if (gen_s.regs[5][2] && gen_s.read_pos < gen_s.block_length) need_byte(off);
      put(OP_READ, ADDR_DATA, 8'($urandom), 16'($urandom), 10'($urandom));
   endtask

   task automatic drive_ctl(input logic [7:0] v);
      logic [31:0] off;
      off = 32'(gen_s.block_base) + 32'(gen_s.read_pos);
      if (v[6] && !gen_s.regs[5][6] && !v[1] &&
          (gen_s.block_kind == KIND_COUNT || gen_s.block_kind == KIND_DATA)) begin
         need_byte(off + HDR_SIZE_LO);
         need_byte(off + HDR_SIZE_HI);
      end
      put(OP_WRITE, ADDR_DRV_CTL, v, 16'($urandom), 10'($urandom));
   endtask

   task automatic tick(input logic [9:0] cyc);
      put(OP_TICK, 16'($urandom), 8'($urandom), 16'($urandom), cyc);
   endtask

   // drive control writes go through drive_ctl so header bytes are loaded first
   task automatic bus_wr(input logic [15:0] addr, input logic [7:0] v);
      if (addr == ADDR_DRV_CTL)
         drive_ctl(v);
      else
         put(OP_WRITE, addr, v, 16'($urandom), 10'($urandom));
   endtask

   // data-port reads go through data_read so the next block byte is loaded first
   task automatic bus_rd(input logic [15:0] addr);
      if (addr == ADDR_DATA)
         data_read();
      else
         put(OP_READ, addr, 8'($urandom), 16'($urandom), 10'($urandom));
   endtask

   function automatic logic [9:0] rand_cycles();
      case ($urandom_range(0, 3))
         0: return 10'($urandom_range(0, 8));
         1: return 10'($urandom);
         default: return 10'($urandom_range(0, 120));
      endcase
   endfunction

   function automatic int pick_gap();
      int n;
      n = $urandom_range(0, 99);
      if (calm || n < 60) return 0;
      if (n < 94) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // one random scenario, mostly well-formed transfer sequences
   task automatic random_scenario();
      logic [7:0]  v;
      logic [15:0] a;
      int n;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: begin
            // start the next block in read mode and read part of it
            v = 8'($urandom) | 8'h05;
            v[1] = ($urandom_range(0, 9) == 0);
            drive_ctl(v & ~8'h40);
            drive_ctl(v | 8'h40);
            n = $urandom_range(0, 20);
            repeat (n) begin
               data_read();
               if ($urandom_range(0, 5) == 0) tick(rand_cycles());
            end
         end
         4: begin
            // transfer reset, then back to a started state
            drive_ctl((8'($urandom) & ~8'h40) | 8'h02);
            drive_ctl((8'($urandom) & ~8'h42) | 8'h05);
         end
         5, 6: begin
            // timer programming and ticking
            bus_wr(ADDR_TMR_LO, 8'($urandom_range(0, 255)));
            bus_wr(ADDR_TMR_HI, ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'd0);
            bus_wr(ADDR_TMR_CTL, 8'($urandom));
            repeat ($urandom_range(1, 6)) tick(rand_cycles());
            bus_rd(ADDR_STATUS);
         end
         7: begin
            repeat ($urandom_range(1, 4)) tick(rand_cycles());
            bus_rd(16'(ADDR_STATUS + $urandom_range(0, 3)));
         end
         8: put(OP_LOAD, 16'($urandom), 8'($urandom), 16'($urandom), 10'($urandom));
         default: begin
            // noise: a read or write near the register window or anywhere on the bus
            v = 8'($urandom);
            if ($urandom_range(0, 1))
               a = 16'(16'h401E + $urandom_range(0, 24));
            else
               a = 16'($urandom);
            if ($urandom_range(0, 1))
               bus_wr(a, v);
            else
               bus_rd(a);
         end
      endcase
   endtask

   task automatic drain();
      while (item_q.size() != 0 || req_tvalid || result_q.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic csr_write(input logic [15:0] v);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      dut_s.seek_delay = v;
      gen_s.seek_delay = v;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // ---------------------------------------------------------------- driver
   always @(negedge clock) begin
      bus_item_t it;
      if (reset) begin
         req_tvalid <= 1'b0;
         gap_left = 0;
      end else if (!req_tvalid || req_taken) begin
         if (gap_left > 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (item_q.size() != 0) begin
            it = item_q.pop_front();
            req_tdata  <= {6'd0, it.cycles, it.disk_index, it.data, it.address};
            req_tuser  <= it.op;
            req_tvalid <= 1'b1;
            gap_left = pick_gap();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------- receiver
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (!held && reqs_in >= 300) begin
            held = 1'b1;
            hold_left = HOLD_LEN;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (rx_gap > 0) begin
            rx_gap--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            rx_gap = pick_gap();
         end
      end
   end

   // ---------------------------------------------------------------- monitor and checker
   always @(posedge clock) begin
      bus_item_t   it;
      bus_result_t want, got;
      req_taken = 1'b0;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            req_taken = 1'b1;
            it = '{op: req_tuser, address: req_tdata[15:0], data: req_tdata[23:16],
                   disk_index: req_tdata[39:24], cycles: req_tdata[49:40]};
            result_q.push_back(drive_step(dut_s, dut_img, it));
            if (it.op == OP_READ && it.address == ADDR_DATA) bytes_read++;
            reqs_in++;
         end
         if (rsp_tvalid && rsp_tready) begin
            got = '{read_data: rsp_tdata[7:0], irq_assert: rsp_tdata[8],
                    irq_clear: rsp_tdata[9], mirror_set: rsp_tdata[10],
                    mirror_horizontal: rsp_tdata[11]};
            rsps_out++;
            if (got.irq_assert) irqs_seen++;
            if (result_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected transfer on rsp: %h", rsp_tdata);
            end else begin
               want = result_q.pop_front();
               if (got !== want || rsp_tdata[15:12] !== 4'd0) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"mismatch at rsp #%0d: exp rd=%h ia=%b ic=%b ms=%b mh=%b,",
                               " got rd=%h ia=%b ic=%b ms=%b mh=%b"},
                              rsps_out, want.read_data, want.irq_assert, want.irq_clear,
                              want.mirror_set, want.mirror_horizontal, got.read_data,
                              got.irq_assert, got.irq_clear, got.mirror_set,
                              got.mirror_horizontal);
               end
            end
         end
         // watchdog: no transfer on any channel for too long
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= WDOG_LIMIT) begin
            $display("watchdog expired, %0d results outstanding", result_q.size());
            $display("[disk_drive_regs_with_irq_timer_unit] ERROR");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------- sequence
   initial begin
      logic [15:0] delays [4];
      int i;
      delays = '{16'd1, 16'd65535, 16'd37, 16'(100 + $urandom_range(0, 400))};
      reset = 1'b1;
      req_tvalid = 1'b0; req_tdata = '0; req_tuser = OP_READ;
      rsp_tready = 1'b0; csr_valid = 1'b0; csr_data = '0;
      reqs_in = 0; rsps_out = 0; mismatches = 0; irqs_seen = 0; bytes_read = 0;
      idle_cycles = 0; held = 1'b0; hold_left = 0; rx_gap = 0; calm = 1'b0;
      gen_s = drive_reset_state();
      dut_s = drive_reset_state();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: register map, unmapped accesses, timer and a block walk
      bus_rd(ADDR_EXT); bus_rd(ADDR_DRIVE); bus_rd(ADDR_STATUS); data_read();
      bus_rd(16'h0000); bus_rd(16'hFFFF);
      bus_wr(16'hFFFF, 8'hFF); bus_wr(16'h4026, 8'h55);
      bus_wr(ADDR_TMR_LO, 8'h05); bus_wr(ADDR_TMR_HI, 8'h00); bus_wr(ADDR_TMR_CTL, 8'h03);
      tick(10'd0); tick(10'd3); tick(10'd1023); bus_rd(ADDR_STATUS);
      bus_wr(ADDR_TMR_LO, 8'h00); bus_wr(ADDR_TMR_CTL, 8'h02); tick(10'd10);
      drive_ctl(8'h03); bus_rd(ADDR_DRIVE);
      drive_ctl(8'hC5); data_read(); data_read();
      drive_ctl(8'h8D); drive_ctl(8'hCD); tick(10'd1023); bus_rd(ADDR_STATUS);
      put(OP_LOAD, 16'h0000, 8'hAA, 16'hFFFF, 10'h3FF);
      drain();

      // random phases, each under its own seek delay
      for (i = 0; i < 5; i++) begin
         calm = (i == 2);
         if (i > 0) csr_write(delays[i-1]);
         while (item_q.size() < PHASE_ITEMS) random_scenario();
         drain();
      end

      $display("run covered %0d items, %0d results, %0d data-port reads, %0d interrupts",
               reqs_in, rsps_out, bytes_read, irqs_seen);
      $display("seek delays 100, 1, 65535, 37 and %0d; %0d mismatches", delays[3], mismatches);
      if (mismatches == 0 && result_q.size() == 0)
         $display("[disk_drive_regs_with_irq_timer_unit] OK");
      else
         $display("[disk_drive_regs_with_irq_timer_unit] ERROR");
      $finish;
   end

endmodule

// File: sim.f
rtl/ddr_irq_pkg.sv
rtl/disk_drive_regs_with_irq_timer_unit.sv
tb/tb_disk_drive_regs_with_irq_timer_unit.sv
